[src/sft_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and constants of the swing foot trajectory block.
// No dependencies; imported by every module of the block.
package sft_pkg;

  localparam int DXW = 27;          // velocity times phase time, Q15.12
  localparam int TLW = 43;          // remaining swing time, Q.32 seconds
  localparam int QW = 17;           // quotient bits resolved by the divider
  localparam int NW = TLW + QW;     // divider remainder width
  localparam int NUMW = NW + 2;     // rounded dividend width
  localparam int TXW = 28;          // touchdown point before saturation
  localparam int CW = 32;           // CORDIC x/y, Q2.30
  localparam int ZW = 18;           // CORDIC residual angle
  localparam int STEPS = 15;        // CORDIC iterations

  localparam logic signed [30:0] TURN_SCALE = 31'sd683565276;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd652032875;
  localparam logic [TLW-1:0] TOUCH_MIN = 43'd4295;

  typedef enum logic [2:0] {
    CFG_STANCE_X  = 3'd0,
    CFG_STANCE_Y  = 3'd1,
    CFG_STANCE_Z  = 3'd2,
    CFG_LIFT      = 3'd3,
    CFG_STEP_TIME = 3'd4,
    CFG_PHASE     = 3'd5,
    CFG_STANCE_T  = 3'd6,
    CFG_SWING     = 3'd7
  } sft_cfg_idx_t;

  // Beat payload that travels alongside the CORDIC.
  typedef struct packed {
    logic signed [15:0]     sx;
    logic signed [15:0]     sy;
    logic signed [15:0]     fx;
    logic signed [15:0]     fy;
    logic signed [15:0]     z;
    logic signed [DXW-1:0]  dx;
    logic signed [DXW-1:0]  dy;
    logic [TLW-1:0]         tl;
    logic                   touch;
  } sft_side_t;

  // Beat payload that travels alongside the divider.
  typedef struct packed {
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] z;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic               neg_x;
    logic               neg_y;
    logic               touch;
  } sft_dside_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Arctangent of 2^-i in units of 2^-16 turn.
  function automatic logic signed [ZW-1:0] atan_unit(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 18'sd8192;
      1:  r = 18'sd4836;
      2:  r = 18'sd2555;
      3:  r = 18'sd1297;
      4:  r = 18'sd651;
      5:  r = 18'sd326;
      6:  r = 18'sd163;
      7:  r = 18'sd81;
      8:  r = 18'sd41;
      9:  r = 18'sd20;
      10: r = 18'sd10;
      11: r = 18'sd5;
      12: r = 18'sd3;
      13: r = 18'sd1;
      14: r = 18'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/sft_cordic.sv]
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC giving cosine and sine of a 16-bit phase.
// Depends on sft_pkg; one quadrant fold stage then one stage per iteration.
module sft_cordic import sft_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [15:0]           in_phase,
  input  sft_side_t             in_side,
  output logic                  out_vld,
  output logic signed [CW-1:0]  out_cos,
  output logic signed [CW-1:0]  out_sin,
  output sft_side_t             out_side
);

  logic                  vld_r  [0:STEPS];
  logic signed [CW-1:0]  x_r    [0:STEPS];
  logic signed [CW-1:0]  y_r    [0:STEPS];
  logic signed [ZW-1:0]  z_r    [0:STEPS];
  logic                  flip_r [0:STEPS];
  sft_side_t             side_r [0:STEPS];

  logic signed [ZW-1:0]  z_in;
  logic signed [ZW-1:0]  z_fold_nxt;
  logic                  flip_nxt;

  // Fold the angle into plus or minus a quarter turn; the result is negated at the end.
  always_comb begin
    z_in = ZW'($signed(in_phase));
    z_fold_nxt = z_in;
    flip_nxt = 1'b0;
    if (z_in > 18'sd16384) begin
      z_fold_nxt = z_in - 18'sd32768;
      flip_nxt = 1'b1;
    end else if (z_in < -18'sd16384) begin
      z_fold_nxt = z_in + 18'sd32768;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    x_r[0] <= CORDIC_GAIN;
    y_r[0] <= '0;
    z_r[0] <= z_fold_nxt;
    flip_r[0] <= flip_nxt;
    side_r[0] <= in_side;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] - ys;
        y_r[i+1] <= y_r[i] + xs;
        z_r[i+1] <= z_r[i] - atan_unit(i);
      end else begin
        x_r[i+1] <= x_r[i] + ys;
        y_r[i+1] <= y_r[i] - xs;
        z_r[i+1] <= z_r[i] + atan_unit(i);
      end
      flip_r[i+1] <= flip_r[i];
      side_r[i+1] <= side_r[i];
    end
  end

  assign out_vld = vld_r[STEPS];
  assign out_cos = flip_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
  assign out_sin = flip_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];
  assign out_side = side_r[STEPS];

endmodule

[src/sft_div.sv]
`timescale 1ns / 1ps
// Two-lane pipelined restoring divider with an overflow pre-check.
// Depends on sft_pkg; one quotient bit per stage, lanes share the divisor.
module sft_div import sft_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [TLW-1:0]   in_den,
  input  logic [NUMW-1:0]  in_num_x,
  input  logic [NUMW-1:0]  in_num_y,
  input  sft_dside_t       in_side,
  output logic             out_vld,
  output logic [QW-1:0]    out_q_x,
  output logic [QW-1:0]    out_q_y,
  output logic             out_ovf_x,
  output logic             out_ovf_y,
  output sft_dside_t       out_side
);

  logic             vld_r  [0:QW];
  logic [TLW-1:0]   den_r  [0:QW];
  logic [NW-1:0]    rx_r   [0:QW];
  logic [NW-1:0]    ry_r   [0:QW];
  logic [QW-1:0]    qx_r   [0:QW];
  logic [QW-1:0]    qy_r   [0:QW];
  logic             ovfx_r [0:QW];
  logic             ovfy_r [0:QW];
  sft_dside_t       side_r [0:QW];

  logic [NUMW-1:0]  den_top;

  // A quotient of 2^17 or more saturates the output whatever the foot position.
  assign den_top = NUMW'({in_den, QW'(0)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    den_r[0] <= in_den;
    rx_r[0] <= in_num_x[NW-1:0];
    ry_r[0] <= in_num_y[NW-1:0];
    qx_r[0] <= '0;
    qy_r[0] <= '0;
    ovfx_r[0] <= (in_num_x >= den_top);
    ovfy_r[0] <= (in_num_y >= den_top);
    side_r[0] <= in_side;
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic [NW-1:0]  dk;
    logic           ge_x;
    logic           ge_y;
    logic [QW-1:0]  qx_nxt;
    logic [QW-1:0]  qy_nxt;

    always_comb begin
      dk = NW'(den_r[j]) << K;
      ge_x = (rx_r[j] >= dk);
      ge_y = (ry_r[j] >= dk);
      qx_nxt = qx_r[j];
      qy_nxt = qy_r[j];
      qx_nxt[K] = ge_x;
      qy_nxt[K] = ge_y;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
      den_r[j+1] <= den_r[j];
      rx_r[j+1] <= ge_x ? rx_r[j] - dk : rx_r[j];
      ry_r[j+1] <= ge_y ? ry_r[j] - dk : ry_r[j];
      qx_r[j+1] <= qx_nxt;
      qy_r[j+1] <= qy_nxt;
      ovfx_r[j+1] <= ovfx_r[j];
      ovfy_r[j+1] <= ovfy_r[j];
      side_r[j+1] <= side_r[j];
    end
  end

  assign out_vld = vld_r[QW];
  assign out_q_x = qx_r[QW];
  assign out_q_y = qy_r[QW];
  assign out_ovf_x = ovfx_r[QW];
  assign out_ovf_y = ovfy_r[QW];
  assign out_side = side_r[QW];

  a_rem_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QW] && !ovfx_r[QW] |-> NW'(den_r[QW]) > rx_r[QW])
    else $error("x remainder not below divisor");

  a_rem_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QW] && !ovfy_r[QW] |-> NW'(den_r[QW]) > ry_r[QW])
    else $error("y remainder not below divisor");

endmodule

[src/swing_foot_trajectory.sv]
`timescale 1ns / 1ps
// Top level of the swing foot trajectory block: configuration registers,
// front and back pipeline stages. Depends on sft_pkg, sft_cordic, sft_div.
//
// Usage
//   Command channel: a beat is taken at a rising edge with start high and
//   busy low. busy is high only during reset and in the cycle that follows
//   it, so a new leg update may be issued in every cycle thereafter.
//   Result channel: out_valid is high for exactly one cycle per beat and the
//   results must be captured in that cycle; there is no back-pressure.
//   The throughput is one beat per cycle. The path of each beat runs
//   through the CORDIC for the yaw rotation and the divider that spreads
//   the remaining distance over the remaining swing time.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index at the
//   clock edge, with no wait. Registers are only to be changed while no
//   beat is in flight, since later stages read them directly.
//   Reset (synchronous, rst_n low) clears every valid bit and loads the
//   configuration defaults; items in flight are dropped.
module swing_foot_trajectory import sft_pkg::*; #(
  parameter int LEG_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration port
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata,
  // Command channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_leg_index,
  input  logic [16:0]         in_swing_progress,
  input  logic signed [15:0]  in_foot_x,
  input  logic signed [15:0]  in_foot_y,
  input  logic signed [15:0]  in_vel_x,
  input  logic signed [15:0]  in_vel_y,
  input  logic signed [15:0]  in_yaw_rate,
  input  logic signed [15:0]  in_body_height,
  // Result channel
  output logic                out_valid,
  output logic signed [15:0]  out_next_x,
  output logic signed [15:0]  out_next_y,
  output logic signed [15:0]  out_next_z,
  output logic                out_at_touchdown
);

  localparam int LATENCY = 43;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [63:0] stance_x_r;
  logic [63:0] stance_y_r;
  logic [63:0] stance_z_r;
  logic [14:0] lift_r;
  logic [15:0] step_r;
  logic [9:0]  phase_ticks_r;
  logic [9:0]  stance_ticks_r;
  logic [9:0]  swing_ticks_r;
  logic        busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stance_x_r <= '0;
      stance_y_r <= '0;
      stance_z_r <= '0;
      lift_r <= '0;
      step_r <= 16'd655;
      phase_ticks_r <= 10'd1;
      stance_ticks_r <= 10'd1;
      swing_ticks_r <= 10'd1;
    end else if (cfg_we) begin
      case (sft_cfg_idx_t'(cfg_index))
        CFG_STANCE_X:  stance_x_r <= cfg_wdata;
        CFG_STANCE_Y:  stance_y_r <= cfg_wdata;
        CFG_STANCE_Z:  stance_z_r <= cfg_wdata;
        CFG_LIFT:      lift_r <= cfg_wdata[14:0];
        CFG_STEP_TIME: step_r <= cfg_wdata[15:0];
        CFG_PHASE:     phase_ticks_r <= cfg_wdata[9:0];
        CFG_STANCE_T:  stance_ticks_r <= cfg_wdata[9:0];
        CFG_SWING:     swing_ticks_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so the block is only busy straight after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;

  // ---------------------------------------------------------------------
  // Stage 1: clamp the command, pick the leg's stance and form the time
  // products that depend only on configuration.
  // ---------------------------------------------------------------------
  logic [1:0]   leg_sel;
  logic [16:0]  prop_c;
  logic [16:0]  rem_c;
  logic [15:0]  plift_c;

  always_comb begin
    leg_sel = (int'(in_leg_index) >= LEG_COUNT) ? 2'(LEG_COUNT - 1) : in_leg_index;
    prop_c = (in_swing_progress > 17'd65536) ? 17'd65536 : in_swing_progress;
    rem_c = 17'd65536 - prop_c;
    // Rising half of the lift triangle uses the progress, the falling half
    // what remains of the swing.
    plift_c = (prop_c[16:15] == 2'b00) ? prop_c[15:0] : rem_c[15:0];
  end

  logic               s1_vld_r;
  logic signed [15:0] s1_fx_r, s1_fy_r, s1_vx_r, s1_vy_r, s1_yaw_r, s1_bh_r;
  logic signed [15:0] s1_sx_r, s1_sy_r, s1_sz_r;
  logic [25:0]        s1_ptime_r, s1_stime_r, s1_swdt_r;
  logic [16:0]        s1_rem_r;
  logic [15:0]        s1_plift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy_r;
    end
    s1_fx_r <= in_foot_x;
    s1_fy_r <= in_foot_y;
    s1_vx_r <= in_vel_x;
    s1_vy_r <= in_vel_y;
    s1_yaw_r <= in_yaw_rate;
    s1_bh_r <= in_body_height;
    s1_sx_r <= stance_x_r[{leg_sel, 4'b0000} +: 16];
    s1_sy_r <= stance_y_r[{leg_sel, 4'b0000} +: 16];
    s1_sz_r <= stance_z_r[{leg_sel, 4'b0000} +: 16];
    s1_ptime_r <= 26'(phase_ticks_r) * 26'(step_r);
    s1_stime_r <= 26'(stance_ticks_r) * 26'(step_r);
    s1_swdt_r <= 26'(swing_ticks_r) * 26'(step_r);
    s1_rem_r <= rem_c;
    s1_plift_r <= plift_c;
  end

  // ---------------------------------------------------------------------
  // Stage 2: velocity and yaw products, remaining swing time, lift product.
  // ---------------------------------------------------------------------
  logic               s2_vld_r;
  logic signed [42:0] s2_vxp_r, s2_vyp_r, s2_yawp_r;
  logic [TLW-1:0]     s2_tl_r;
  logic [30:0]        s2_hp_r;
  logic signed [15:0] s2_fx_r, s2_fy_r, s2_bh_r, s2_sx_r, s2_sy_r, s2_sz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_vxp_r <= s1_vx_r * $signed({1'b0, s1_ptime_r});
    s2_vyp_r <= s1_vy_r * $signed({1'b0, s1_ptime_r});
    s2_yawp_r <= s1_yaw_r * $signed({1'b0, s1_stime_r});
    s2_tl_r <= s1_swdt_r * s1_rem_r;
    s2_hp_r <= s1_plift_r * lift_r;
    s2_fx_r <= s1_fx_r;
    s2_fy_r <= s1_fy_r;
    s2_bh_r <= s1_bh_r;
    s2_sx_r <= s1_sx_r;
    s2_sy_r <= s1_sy_r;
    s2_sz_r <= s1_sz_r;
  end

  // ---------------------------------------------------------------------
  // Stage 3: round the products, decide touchdown and settle z, which
  // needs nothing from the rotation.
  // ---------------------------------------------------------------------
  logic signed [42:0] vxr, vyr, yawr;
  logic [31:0]        hr;
  logic signed [17:0] hz;
  sft_side_t          s3_side_nxt;

  always_comb begin
    vxr = s2_vxp_r + 43'sd32768;
    vyr = s2_vyp_r + 43'sd32768;
    yawr = s2_yawp_r + 43'sd2048;
    hr = {1'b0, s2_hp_r} + 32'd16384;
    hz = $signed({1'b0, hr[31:15]}) + 18'(s2_bh_r);
    s3_side_nxt.sx = s2_sx_r;
    s3_side_nxt.sy = s2_sy_r;
    s3_side_nxt.fx = s2_fx_r;
    s3_side_nxt.fy = s2_fy_r;
    s3_side_nxt.dx = vxr[42:16];
    s3_side_nxt.dy = vyr[42:16];
    s3_side_nxt.tl = s2_tl_r;
    s3_side_nxt.touch = (s2_tl_r < TOUCH_MIN);
    // At touchdown the stance height stands without the body offset.
    s3_side_nxt.z = s3_side_nxt.touch ? s2_sz_r : sat16(32'(hz));
  end

  logic               s3_vld_r;
  logic signed [30:0] s3_th_r;
  sft_side_t          s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_th_r <= yawr[42:12];
    s3_side_r <= s3_side_nxt;
  end

  // ---------------------------------------------------------------------
  // Stage 4: yaw angle in radians to a turn fraction.
  // ---------------------------------------------------------------------
  logic signed [61:0] th_turn;
  logic               s4_vld_r;
  logic [47:0]        s4_thp_r;
  sft_side_t          s4_side_r;
  logic [47:0]        phase_sum;

  assign th_turn = s3_th_r * TURN_SCALE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_thp_r <= th_turn[47:0];
    s4_side_r <= s3_side_r;
  end

  // Only 16 bits of turn survive; wraps beyond a full turn fall away here.
  assign phase_sum = s4_thp_r + 48'h0000_8000_0000;

  // ---------------------------------------------------------------------
  // CORDIC: cosine and sine of the yaw turn.
  // ---------------------------------------------------------------------
  logic                 cor_vld;
  logic signed [CW-1:0] cor_cos, cor_sin;
  sft_side_t            cor_side;

  sft_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s4_vld_r),
    .in_phase (phase_sum[47:32]),
    .in_side  (s4_side_r),
    .out_vld  (cor_vld),
    .out_cos  (cor_cos),
    .out_sin  (cor_sin),
    .out_side (cor_side)
  );

  // ---------------------------------------------------------------------
  // Stage 6: the four rotation products.
  // ---------------------------------------------------------------------
  logic               s6_vld_r;
  logic signed [47:0] s6_csx_r, s6_ssy_r, s6_ssx_r, s6_csy_r;
  sft_side_t          s6_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= cor_vld;
    end
    s6_csx_r <= cor_cos * cor_side.sx;
    s6_ssy_r <= cor_sin * cor_side.sy;
    s6_ssx_r <= cor_sin * cor_side.sx;
    s6_csy_r <= cor_cos * cor_side.sy;
    s6_side_r <= cor_side;
  end

  // ---------------------------------------------------------------------
  // Stage 7: touchdown point.
  // ---------------------------------------------------------------------
  logic signed [48:0] rot_x, rot_y;
  logic               s7_vld_r;
  logic signed [TXW-1:0] s7_tx_r, s7_ty_r;
  sft_side_t          s7_side_r;

  always_comb begin
    rot_x = 49'(s6_csx_r) - 49'(s6_ssy_r) + 49'sd536870912;
    rot_y = 49'(s6_ssx_r) + 49'(s6_csy_r) + 49'sd536870912;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= s6_vld_r;
    end
    s7_tx_r <= TXW'($signed(rot_x[48:30])) + TXW'(s6_side_r.dx);
    s7_ty_r <= TXW'($signed(rot_y[48:30])) + TXW'(s6_side_r.dy);
    s7_side_r <= s6_side_r;
  end

  // ---------------------------------------------------------------------
  // Stage 8: remaining distance times step time.
  // ---------------------------------------------------------------------
  logic signed [TXW:0] dist_x, dist_y;
  logic               s8_vld_r;
  logic signed [45:0] s8_num_x_r, s8_num_y_r;
  logic [TLW-1:0]     s8_tl_r;
  sft_dside_t         s8_dside_r;

  assign dist_x = (TXW+1)'(s7_tx_r) - (TXW+1)'(s7_side_r.fx);
  assign dist_y = (TXW+1)'(s7_ty_r) - (TXW+1)'(s7_side_r.fy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else begin
      s8_vld_r <= s7_vld_r;
    end
    s8_num_x_r <= dist_x * $signed({1'b0, step_r});
    s8_num_y_r <= dist_y * $signed({1'b0, step_r});
    s8_tl_r <= s7_side_r.tl;
    s8_dside_r.fx <= s7_side_r.fx;
    s8_dside_r.fy <= s7_side_r.fy;
    s8_dside_r.z <= s7_side_r.z;
    s8_dside_r.tx <= sat16(32'(s7_tx_r));
    s8_dside_r.ty <= sat16(32'(s7_ty_r));
    s8_dside_r.neg_x <= 1'b0;
    s8_dside_r.neg_y <= 1'b0;
    s8_dside_r.touch <= s7_side_r.touch;
  end

  // ---------------------------------------------------------------------
  // Stage 9: sign and magnitude of the dividend, rounded by half a divisor
  // so that the division rounds to nearest with ties away from zero.
  // ---------------------------------------------------------------------
  logic [45:0]      mag_x, mag_y;
  logic             s9_vld_r;
  logic [NUMW-1:0]  s9_num_x_r, s9_num_y_r;
  logic [TLW-1:0]   s9_tl_r;
  sft_dside_t       s9_dside_r;

  assign mag_x = s8_num_x_r[45] ? 46'(-s8_num_x_r) : 46'(s8_num_x_r);
  assign mag_y = s8_num_y_r[45] ? 46'(-s8_num_y_r) : 46'(s8_num_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_vld_r <= 1'b0;
    end else begin
      s9_vld_r <= s8_vld_r;
    end
    s9_num_x_r <= NUMW'({mag_x, 16'h0000}) + NUMW'(s8_tl_r >> 1);
    s9_num_y_r <= NUMW'({mag_y, 16'h0000}) + NUMW'(s8_tl_r >> 1);
    s9_tl_r <= s8_tl_r;
    s9_dside_r.fx <= s8_dside_r.fx;
    s9_dside_r.fy <= s8_dside_r.fy;
    s9_dside_r.z <= s8_dside_r.z;
    s9_dside_r.tx <= s8_dside_r.tx;
    s9_dside_r.ty <= s8_dside_r.ty;
    s9_dside_r.neg_x <= s8_num_x_r[45];
    s9_dside_r.neg_y <= s8_num_y_r[45];
    s9_dside_r.touch <= s8_dside_r.touch;
  end

  // ---------------------------------------------------------------------
  // Divider: the step's share of the remaining distance.
  // ---------------------------------------------------------------------
  logic             div_vld;
  logic [QW-1:0]    div_q_x, div_q_y;
  logic             div_ovf_x, div_ovf_y;
  sft_dside_t       div_side;

  sft_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (s9_vld_r),
    .in_den    (s9_tl_r),
    .in_num_x  (s9_num_x_r),
    .in_num_y  (s9_num_y_r),
    .in_side   (s9_dside_r),
    .out_vld   (div_vld),
    .out_q_x   (div_q_x),
    .out_q_y   (div_q_y),
    .out_ovf_x (div_ovf_x),
    .out_ovf_y (div_ovf_y),
    .out_side  (div_side)
  );

  // ---------------------------------------------------------------------
  // Output stage: apply the step, saturate, choose touchdown or swing.
  // ---------------------------------------------------------------------
  logic signed [18:0] sum_x, sum_y;
  logic signed [15:0] swing_x, swing_y;

  always_comb begin
    sum_x = div_side.neg_x ? 19'(div_side.fx) - $signed({2'b00, div_q_x})
                           : 19'(div_side.fx) + $signed({2'b00, div_q_x});
    sum_y = div_side.neg_y ? 19'(div_side.fy) - $signed({2'b00, div_q_y})
                           : 19'(div_side.fy) + $signed({2'b00, div_q_y});
    // An overflowing quotient pushes the foot to the rail on the side of its sign.
    if (div_ovf_x) begin
      swing_x = div_side.neg_x ? 16'sh8000 : 16'sh7FFF;
    end else begin
      swing_x = sat16(32'(sum_x));
    end
    if (div_ovf_y) begin
      swing_y = div_side.neg_y ? 16'sh8000 : 16'sh7FFF;
    end else begin
      swing_y = sat16(32'(sum_y));
    end
  end

  logic               out_valid_r;
  logic signed [15:0] out_x_r, out_y_r, out_z_r;
  logic               out_td_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_vld;
    end
    out_x_r <= div_side.touch ? div_side.tx : swing_x;
    out_y_r <= div_side.touch ? div_side.ty : swing_y;
    out_z_r <= div_side.z;
    out_td_r <= div_side.touch;
  end

  assign out_valid = out_valid_r;
  assign out_next_x = out_x_r;
  assign out_next_y = out_y_r;
  assign out_next_z = out_z_r;
  assign out_at_touchdown = out_td_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_beat_arrives: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("command beat produced no result beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LATENCY !out_valid)
    else $error("result beat without a command beat");

  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset recovery");

endmodule

[bench/swing_foot_trajectory_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the swing foot trajectory block.
// Depends on sft_pkg and swing_foot_trajectory; drives directed and random beats.
module swing_foot_trajectory_tb import sft_pkg::*;;

  // One leg update as it goes into the block.
  typedef struct {
    logic [1:0]         leg;
    logic [16:0]        prog;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] yaw;
    logic signed [15:0] bh;
  } leg_cmd_t;

  // One foot target as it leaves the block.
  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               td;
  } foot_target_t;

  // A row of the directed table: the command and, where it is obvious,
  // the foot target that it must produce.
  typedef struct {
    leg_cmd_t     cmd;
    bit           typed;
    foot_target_t tgt;
  } stim_row_t;

  typedef struct {
    logic [63:0] sx;
    logic [63:0] sy;
    logic [63:0] sz;
    logic [14:0] lift;
    logic [15:0] step;
    logic [9:0]  ph_t;
    logic [9:0]  st_t;
    logic [9:0]  sw_t;
  } gait_cfg_t;

  localparam longint TURN = 64'sd683565276;
  localparam longint GAIN = 64'sd652032875;
  localparam int     LATENCY = 43;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [63:0]        cfg_wdata;
  logic               start;
  logic               busy;
  logic [1:0]         in_leg_index;
  logic [16:0]        in_swing_progress;
  logic signed [15:0] in_foot_x;
  logic signed [15:0] in_foot_y;
  logic signed [15:0] in_vel_x;
  logic signed [15:0] in_vel_y;
  logic signed [15:0] in_yaw_rate;
  logic signed [15:0] in_body_height;
  logic               out_valid;
  logic signed [15:0] out_next_x;
  logic signed [15:0] out_next_y;
  logic signed [15:0] out_next_z;
  logic               out_at_touchdown;

  // The predictor's own copy of the configuration registers.
  gait_cfg_t cur_cfg;

  // Foot targets still owed by the block, oldest first.
  foot_target_t pending_targets[$];
  int unsigned  mismatches;
  int unsigned  beats_sent;
  int unsigned  touchdowns_seen;
  int unsigned  swings_seen;

  swing_foot_trajectory dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_leg_index     (in_leg_index),
    .in_swing_progress(in_swing_progress),
    .in_foot_x        (in_foot_x),
    .in_foot_y        (in_foot_y),
    .in_vel_x         (in_vel_x),
    .in_vel_y         (in_vel_y),
    .in_yaw_rate      (in_yaw_rate),
    .in_body_height   (in_body_height),
    .out_valid        (out_valid),
    .out_next_x       (out_next_x),
    .out_next_y       (out_next_y),
    .out_next_z       (out_next_z),
    .out_at_touchdown (out_at_touchdown)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Rounding half up at a binary point s places in: an arithmetic shift of
  // a signed value is a floor, so adding half first gives round half up.
  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Division rounding to nearest, ties away from zero; den is positive.
  function automatic longint div_nearest(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Foot target predictor. The yaw angle is turned into a 16-bit turn
  // fraction, folded into +-90 degrees and resolved by a 15-step CORDIC; the
  // rotated stance point plus the velocity offset gives the touchdown point.
  function automatic foot_target_t predict_target(leg_cmd_t c);
    foot_target_t r;
    longint sx, sy, sz, dt, ptime, stime, th, ang, cs, sn, tx, ty, tl;
    longint prog, xs, ys, lift, h;
    longint z;
    bit flip;
    logic [15:0] ph;
    int leg;
    leg = c.leg;
    prog = c.prog;
    if (prog > 65536) begin
      prog = 65536;
    end
    sx = longint'($signed(cur_cfg.sx[16*leg +: 16]));
    sy = longint'($signed(cur_cfg.sy[16*leg +: 16]));
    sz = longint'($signed(cur_cfg.sz[16*leg +: 16]));
    dt = longint'(cur_cfg.step);
    ptime = longint'(cur_cfg.ph_t) * dt;
    stime = longint'(cur_cfg.st_t) * dt;
    th = round_shift(longint'(c.yaw) * stime, 12);
    ang = round_shift(th * TURN, 32);
    ph = ang[15:0];
    z = longint'($signed(ph));
    flip = 1'b0;
    if (z > 16384) begin
      z -= 32768;
      flip = 1'b1;
    end else if (z < -16384) begin
      z += 32768;
      flip = 1'b1;
    end
    cs = GAIN;
    sn = 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = cs >>> i;
      ys = sn >>> i;
      if (z >= 0) begin
        cs -= ys;
        sn += xs;
        z -= longint'(atan_unit(i));
      end else begin
        cs += ys;
        sn -= xs;
        z += longint'(atan_unit(i));
      end
    end
    if (flip) begin
      cs = -cs;
      sn = -sn;
    end
    tx = round_shift(cs * sx - sn * sy, 30) + round_shift(longint'(c.vx) * ptime, 16);
    ty = round_shift(sn * sx + cs * sy, 30) + round_shift(longint'(c.vy) * ptime, 16);
    tl = longint'(cur_cfg.sw_t) * dt * (65536 - prog);
    if (tl < 4295) begin
      r.nx = clip16(tx);
      r.ny = clip16(ty);
      r.nz = clip16(sz);
      r.td = 1'b1;
    end else begin
      lift = longint'(cur_cfg.lift);
      h = (prog < 32768) ? round_shift(prog * lift, 15)
                         : round_shift((65536 - prog) * lift, 15);
      r.nx = clip16(longint'(c.fx) + div_nearest((tx - longint'(c.fx)) * dt * 65536, tl));
      r.ny = clip16(longint'(c.fy) + div_nearest((ty - longint'(c.fy)) * dt * 65536, tl));
      r.nz = clip16(h + longint'(c.bh));
      r.td = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Result monitor. The block cannot be held off, so every strobed beat is
  // taken at the edge that ends its cycle and checked against the oldest
  // foot target still owed.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_targets.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        foot_target_t w;
        w = pending_targets.pop_front();
        if (out_next_x !== w.nx) report_mismatch("next_x", out_next_x, w.nx);
        if (out_next_y !== w.ny) report_mismatch("next_y", out_next_y, w.ny);
        if (out_next_z !== w.nz) report_mismatch("next_z", out_next_z, w.nz);
        if (out_at_touchdown !== w.td) begin
          report_mismatch("at_touchdown", out_at_touchdown, w.td);
        end
        if (w.td) touchdowns_seen++;
        else swings_seen++;
      end
    end
  end

  // Presents one command beat from the current edge and holds it until the
  // block takes it. Returns at the accepting edge with start still high, so
  // the caller either presents the next beat or lowers start there.
  task automatic send_beat(leg_cmd_t c, bit typed, foot_target_t tgt);
    start             <= 1'b1;
    in_leg_index      <= c.leg;
    in_swing_progress <= c.prog;
    in_foot_x         <= c.fx;
    in_foot_y         <= c.fy;
    in_vel_x          <= c.vx;
    in_vel_y          <= c.vy;
    in_yaw_rate       <= c.yaw;
    in_body_height    <= c.bh;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_targets.push_back(typed ? tgt : predict_target(c));
    beats_sent++;
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Lets the pipeline empty before the registers are touched again.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_targets.size() != 0) @(posedge clk);
    repeat (LATENCY / 4) @(posedge clk);
  endtask

  // Writes all eight registers on consecutive edges. Narrow registers get
  // random junk above their width, which the block must ignore.
  task automatic load_gait(gait_cfg_t g);
    logic [63:0] d [8];
    d[CFG_STANCE_X]  = g.sx;
    d[CFG_STANCE_Y]  = g.sy;
    d[CFG_STANCE_Z]  = g.sz;
    d[CFG_LIFT]      = 64'({$urandom(), $urandom(), 15'd0}) | 64'(g.lift);
    d[CFG_STEP_TIME] = 64'({$urandom(), $urandom(), 16'd0}) | 64'(g.step);
    d[CFG_PHASE]     = 64'({$urandom(), $urandom(), 10'd0}) | 64'(g.ph_t);
    d[CFG_STANCE_T]  = 64'({$urandom(), $urandom(), 10'd0}) | 64'(g.st_t);
    d[CFG_SWING]     = 64'({$urandom(), $urandom(), 10'd0}) | 64'(g.sw_t);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= d[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = g;
    @(posedge clk);
  endtask

  // Mostly small magnitudes so the rotation and the swing step stay in
  // range, with full-range values often enough to reach saturation.
  function automatic logic signed [15:0] pick_q412();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($signed(12'($urandom())));
    endcase
  endfunction

  function automatic logic [63:0] pick_stance4();
    logic [63:0] v;
    for (int i = 0; i < 4; i++) v[16*i +: 16] = pick_q412();
    return v;
  endfunction

  function automatic leg_cmd_t pick_cmd();
    leg_cmd_t c;
    c.leg = 2'($urandom());
    case ($urandom_range(0, 9))
      0: c.prog = 17'($urandom_range(65537, 131071));
      1, 2: c.prog = 17'($urandom_range(65500, 65536));
      default: c.prog = 17'($urandom_range(0, 65536));
    endcase
    c.fx  = pick_q412();
    c.fy  = pick_q412();
    c.vx  = pick_q412();
    c.vy  = pick_q412();
    c.yaw = pick_q412();
    c.bh  = pick_q412();
    return c;
  endfunction

  function automatic gait_cfg_t pick_gait();
    gait_cfg_t g;
    g.sx   = pick_stance4();
    g.sy   = pick_stance4();
    g.sz   = pick_stance4();
    g.lift = 15'($urandom());
    g.step = $urandom_range(0, 1) ? 16'($urandom_range(100, 2000)) : 16'($urandom());
    g.ph_t = $urandom_range(0, 1) ? 10'($urandom_range(1, 40)) : 10'($urandom());
    g.st_t = $urandom_range(0, 1) ? 10'($urandom_range(1, 40)) : 10'($urandom());
    g.sw_t = $urandom_range(0, 1) ? 10'($urandom_range(1, 40)) : 10'($urandom());
    return g;
  endfunction

  function automatic leg_cmd_t make_cmd(logic [1:0] leg, logic [16:0] prog,
                                         logic signed [15:0] fx, logic signed [15:0] fy,
                                         logic signed [15:0] vx, logic signed [15:0] vy,
                                         logic signed [15:0] yaw, logic signed [15:0] bh);
    leg_cmd_t c;
    c = '{leg, prog, fx, fy, vx, vy, yaw, bh};
    return c;
  endfunction

  initial begin
    #(12ns * 400000);
    $display("Timeout waiting for the block to finish");
    $display("Mismatches found");
    $finish;
  end

  initial begin
    stim_row_t    table_rows[$];
    gait_cfg_t    g;
    foot_target_t none;
    int           per_phase;

    none = '{16'sd0, 16'sd0, 16'sd0, 1'b0};
    mismatches = 0;
    beats_sent = 0;
    touchdowns_seen = 0;
    swings_seen = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    start = 1'b0;
    in_leg_index = '0;
    in_swing_progress = '0;
    in_foot_x = '0;
    in_foot_y = '0;
    in_vel_x = '0;
    in_vel_y = '0;
    in_yaw_rate = '0;
    in_body_height = '0;
    cur_cfg = '{64'd0, 64'd0, 64'd0, 15'd0, 16'd655, 10'd1, 10'd1, 10'd1};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. After reset the stance registers are zero, so with
    // zero velocity a complete swing lands exactly on the origin, and a
    // progress past complete must behave as complete.
    table_rows.push_back('{make_cmd(0, 65536, 0, 0, 0, 0, 0, 0), 1'b1,
                           '{16'sd0, 16'sd0, 16'sd0, 1'b1}});
    table_rows.push_back('{make_cmd(3, 131071, 16'sh7FFF, 16'sh8000, 0, 0, 0, 16'sh7FFF),
                           1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b1}});
    table_rows.push_back('{make_cmd(1, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                    16'sh7FFF, 16'sh7FFF), 1'b0, none});
    table_rows.push_back('{make_cmd(2, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                                    16'sh8000, 16'sh8000), 1'b0, none});
    table_rows.push_back('{make_cmd(0, 32767, 100, -100, 4096, -4096, 4096, 0), 1'b0, none});
    table_rows.push_back('{make_cmd(1, 32768, -100, 100, -4096, 4096, -4096, 0), 1'b0, none});
    table_rows.push_back('{make_cmd(2, 65529, 0, 0, 2000, 2000, 12868, 4096), 1'b0, none});
    table_rows.push_back('{make_cmd(3, 65530, 0, 0, 2000, 2000, -12868, 4096), 1'b0, none});
    table_rows.push_back('{make_cmd(0, 65535, 16'sh7FFF, 0, 0, 0, 16'sh7FFF, -4096),
                           1'b0, none});
    table_rows.push_back('{make_cmd(1, 65537, 0, 16'sh8000, 16'sh7FFF, 16'sh8000,
                                    25736, 0), 1'b0, none});
    table_rows.push_back('{make_cmd(2, 16384, 1, -1, 1, -1, 1, -1), 1'b0, none});
    table_rows.push_back('{make_cmd(3, 49152, 0, 0, 0, 0, -25736, 0), 1'b0, none});

    // First walk at the reset settings, then a second walk with large
    // stance offsets and the largest lift, checked against the predictor.
    foreach (table_rows[i]) begin
      send_beat(table_rows[i].cmd, table_rows[i].typed, table_rows[i].tgt);
    end
    drain_pipeline();
    g = '{64'h7FFF_8000_1000_F000, 64'h8000_7FFF_F000_1000, 64'h1234_8000_7FFF_EDCC,
          15'h7FFF, 16'd655, 10'd20, 10'd20, 10'd10};
    load_gait(g);
    foreach (table_rows[i]) send_beat(table_rows[i].cmd, 1'b0, none);
    drain_pipeline();

    // Random phases, each under its own settings. The first two are the
    // extremes: lift and timing at their top with the stance at the rails,
    // then all at zero, where the missing step time forces touchdown throughout.
    per_phase = 220;
    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        g = '{64'h7FFF_7FFF_8000_8000, 64'h8000_7FFF_8000_7FFF, 64'h7FFF_8000_7FFF_8000,
              15'h7FFF, 16'hFFFF, 10'h3FF, 10'h3FF, 10'h3FF};
      end else if (p == 1) begin
        g = '{64'd0, 64'd0, 64'd0, 15'd0, 16'd0, 10'd0, 10'd0, 10'd0};
      end else begin
        g = pick_gait();
      end
      load_gait(g);
      for (int n = 0; n < per_phase; n++) begin
        // A stretch in the middle of each phase runs back to back.
        if ((n < 80 || n >= 150) && $urandom_range(0, 99) < 13) begin
          idle_cycles($urandom_range(1, 2));
        end
        send_beat(pick_cmd(), 1'b0, none);
      end
      drain_pipeline();
    end

    repeat (LATENCY) @(posedge clk);
    $display("Sent %0d leg updates over eight register settings.", beats_sent);
    $display("Checked %0d touchdown and %0d swinging foot targets.",
             touchdowns_seen, swings_seen);
    if (mismatches == 0 && pending_targets.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
src/sft_pkg.sv
src/sft_cordic.sv
src/sft_div.sv
src/swing_foot_trajectory.sv
bench/swing_foot_trajectory_tb.sv
